FILE: rtl/arp_cache_lookup_insert_top_assert.svh
// ----------------------------------------------------------------------------
// ARP cache assertion macros
// Implication checks, same-cycle and next-cycle, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_LOOKUP_INSERT_TOP_ASSERT_SVH
`define ARP_CACHE_LOOKUP_INSERT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arp cache: same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arp cache: next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Field widths, status and operation codes, table entry and FSM types.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int TableEntriesDef = 16;
  localparam int IpW             = 32;
  localparam int MacW            = 48;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } arpc_op_t;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } arpc_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } arpc_state_t;

  // one table row: address and its MAC, stored side by side
  typedef struct packed {
    logic [MacW-1:0] mac;
    logic [IpW-1:0]  ip;
  } arpc_entry_t;

endpackage

FILE: rtl/arpc_table.sv
// ----------------------------------------------------------------------------
// ARP cache table
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module arpc_table
  import arpc_pkg::*;
#(
  parameter int  ENTRIES = TableEntriesDef,
  localparam int AddrW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  arpc_entry_t      wr_entry,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output arpc_entry_t      rd_entry
);

  arpc_entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/arp_cache_lookup_insert_top.sv
// ----------------------------------------------------------------------------
// ARP cache, lookup and insert
// IPv4-to-MAC cache of TABLE_ENTRIES rows held in one synchronous RAM. A
// lookup item walks the rows in index order, one RAM read a cycle, and stops
// at the first row whose address matches (hit, with its MAC) or after the
// last row in use (miss). An insert item writes the lowest free row and
// bumps the used count, or reports full. Rows are never evicted, so the rows
// in use are always 0 .. used_count-1; no valid bits are kept. The single
// RAM read port has registered read data, so the scan reads one row ahead
// of the compare; a lookup on an empty table misses without a read. Each
// result waits in S_HOLD until the output register is free. One item is in
// the engine at a time; the output register lets the next item be taken
// while a result still waits.
// ----------------------------------------------------------------------------
`include "arp_cache_lookup_insert_top_assert.svh"

module arp_cache_lookup_insert_top
  import arpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // [31:0] ipv4_addr, [79:32] resolved_mac
  input  logic [0:0]  s_axis_tuser,  // [0] op
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [47:0] mac_out
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int AddrW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW  = $clog2(TABLE_ENTRIES + 1);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  arpc_state_t     state,        state_next;
  logic [CntW-1:0] used_count,   used_count_next;
  logic [CntW-1:0] issue_idx,    issue_idx_next;   // next row to read
  logic            rd_pend,      rd_pend_next;     // RAM data is valid now
  logic            rd_last,      rd_last_next;     // ... and it is the last row
  logic [IpW-1:0]  key_ip,       key_ip_next;
  arpc_status_t    res_status,   res_status_next;
  logic [MacW-1:0] res_mac,      res_mac_next;
  logic            out_valid,    out_valid_next;
  arpc_status_t    out_status,   out_status_next;
  logic [MacW-1:0] out_mac,      out_mac_next;

  // RAM ports
  logic            wr_en;
  logic            rd_en;
  arpc_entry_t     wr_entry;
  arpc_entry_t     rd_entry;

  logic            in_fire;
  logic            issuing;
  logic            table_full;
  arpc_op_t        in_op;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_op         = arpc_op_t'(s_axis_tuser[0]);
  assign table_full    = (used_count == CntW'(TABLE_ENTRIES));
  assign issuing       = (issue_idx < used_count);

  assign wr_entry.ip   = s_axis_tdata[IpW-1:0];
  assign wr_entry.mac  = s_axis_tdata[IpW+MacW-1:IpW];

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_mac;
  assign m_axis_tuser  = out_status;

  // the table; inserts write at the used count, the scan reads at issue_idx.
  // Only one item is in flight, so a write always lands before any read of it.
  arpc_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (used_count[AddrW-1:0]),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (issue_idx[AddrW-1:0]),
    .rd_entry (rd_entry)
  );

  // --------------------------------------------------------------------------
  // state register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      issue_idx  <= '0;
      rd_pend    <= 1'b0;
      rd_last    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      issue_idx  <= issue_idx_next;
      rd_pend    <= rd_pend_next;
      rd_last    <= rd_last_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    key_ip     <= key_ip_next;
    res_status <= res_status_next;
    res_mac    <= res_mac_next;
    out_status <= out_status_next;
    out_mac    <= out_mac_next;
  end

  // --------------------------------------------------------------------------
  // next state and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    used_count_next = used_count;
    issue_idx_next  = issue_idx;
    rd_pend_next    = rd_pend;
    rd_last_next    = rd_last;
    key_ip_next     = key_ip;
    res_status_next = res_status;
    res_mac_next    = res_mac;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_mac_next    = out_mac;
    wr_en           = 1'b0;
    rd_en           = 1'b0;

    // output register drains independently of the engine
    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          key_ip_next  = s_axis_tdata[IpW-1:0];
          res_mac_next = '0;
          if (in_op == OP_INSERT) begin
            if (table_full) begin
              res_status_next = ST_FULL;
            end else begin
              wr_en           = 1'b1;
              used_count_next = CntW'(used_count + 1'b1);
              res_status_next = ST_INSERTED;
            end
            state_next = S_HOLD;
          end else begin
            issue_idx_next = '0;
            rd_pend_next   = 1'b0;
            rd_last_next   = 1'b0;
            state_next     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read one row ahead of the compare
        rd_en        = issuing;
        rd_pend_next = issuing;
        rd_last_next = (issue_idx == CntW'(used_count - 1'b1));
        if (issuing) begin
          issue_idx_next = CntW'(issue_idx + 1'b1);
        end

        if (used_count == '0) begin
          res_status_next = ST_MISS;
          state_next      = S_HOLD;
        end else if (rd_pend) begin
          if (rd_entry.ip == key_ip) begin
            res_status_next = ST_HIT;
            res_mac_next    = rd_entry.mac;
            state_next      = S_HOLD;
          end else if (rd_last) begin
            res_status_next = ST_MISS;
            state_next      = S_HOLD;
          end
        end
      end

      S_HOLD: begin
        // hand the result over once the output register is free
        if (!out_valid || m_axis_tready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_mac_next    = res_mac;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, used_count <= CntW'(TABLE_ENTRIES))
  `ASSERT_NEXT(a_full_keeps, clk, rst, in_fire && in_op == OP_INSERT && table_full, $stable(used_count))
  `ASSERT_IMPL(a_write_on_accept, clk, rst, wr_en, in_fire && state == S_IDLE)
  `ASSERT_NEXT(a_hold_loads, clk, rst, state == S_HOLD && !out_valid, out_valid && state == S_IDLE)

endmodule

FILE: dv/arp_cache_lookup_insert_top_tb.sv
// ----------------------------------------------------------------------------
// ARP cache lookup/insert testbench
// Streams lookup and insert items into the cache, predicts each status and MAC
// from a shadow copy of the table and checks every result item in order.
// Both stream sides idle in random bursts; the result side holds off once for
// a long stretch so that the cache backs up and stalls its input.
// ----------------------------------------------------------------------------
module arp_cache_lookup_insert_top_tb
  import arpc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Entries    = TableEntriesDef;
  localparam int RandItems  = 1500;
  localparam int StallLimit = 2000;  // cycles with no item moving, while work is left
  localparam int HoldCycles = 300;   // long result-side hold-off
  localparam int TailCycles = 40;    // extra wait at the end, after the last result

  typedef struct {
    arpc_op_t         op;
    logic [IpW-1:0]   ip;
    logic [MacW-1:0]  mac;
  } cache_req_t;

  typedef struct {
    arpc_status_t     status;
    logic [MacW-1:0]  mac;
  } cache_resp_t;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [79:0]       s_axis_tdata;   // [31:0] ipv4_addr, [79:32] resolved_mac
  logic [0:0]        s_axis_tuser;   // [0] op
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [47:0]       m_axis_tdata;   // [47:0] mac_out
  logic [1:0]        m_axis_tuser;   // [1:0] status

  cache_req_t        pending_reqs[$];    // items still to be offered
  cache_resp_t       expected_resps[$];  // predicted results, oldest first
  logic [IpW-1:0]    known_ips[$];       // addresses stored by the stimulus

  // shadow of the cache contents; rows in use are always 0 .. shadow_used-1
  logic [IpW-1:0]    shadow_ip[Entries];
  logic [MacW-1:0]   shadow_mac[Entries];
  int                shadow_used;

  int                n_errors;
  int                n_results;
  int                stall_cycles;
  int                src_gap;
  int                sink_hold;
  bit                in_taken;
  bit                held_off;

  arp_cache_lookup_insert_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  // Idling only away from the tail, and with calm stretches in between.
  function automatic bit idling_allowed();
    return pending_reqs.size() > 150 && (pending_reqs.size() % 256) >= 64;
  endfunction

  function automatic logic [MacW-1:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic queue_item(arpc_op_t op, logic [IpW-1:0] ip, logic [MacW-1:0] mac);
    cache_req_t req;
    req.op  = op;
    req.ip  = ip;
    req.mac = mac;
    pending_reqs.push_back(req);
    if (op == OP_INSERT && known_ips.size() < Entries)
      known_ips.push_back(ip);
  endtask

  // Works out the result of one accepted item and updates the shadow table.
  task automatic predict_cache_resp(cache_req_t req);
    cache_resp_t resp;
    resp.status = ST_MISS;
    resp.mac    = '0;
    if (req.op == OP_LOOKUP) begin
      // lowest matching row wins, so duplicates return the first MAC stored
      for (int i = 0; i < shadow_used; i++) begin
        if (shadow_ip[i] == req.ip) begin
          resp.status = ST_HIT;
          resp.mac    = shadow_mac[i];
          break;
        end
      end
    end else if (shadow_used < Entries) begin
      shadow_ip[shadow_used]  = req.ip;
      shadow_mac[shadow_used] = req.mac;
      shadow_used++;
      resp.status = ST_INSERTED;
    end else begin
      resp.status = ST_FULL;
    end
    expected_resps.push_back(resp);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: samples both sides at the rising edge, predicts and checks.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cache_req_t  req;
    cache_resp_t exp_resp;
    bit          moved;
    in_taken = 1'b0;
    moved    = 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        req.op  = arpc_op_t'(s_axis_tuser[0]);
        req.ip  = s_axis_tdata[31:0];
        req.mac = s_axis_tdata[79:32];
        predict_cache_resp(req);
        in_taken = 1'b1;
        moved    = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        n_results++;
        if (expected_resps.size() == 0) begin
          $error("unexpected result item: status %0d mac %h", m_axis_tuser, m_axis_tdata);
          n_errors++;
        end else begin
          exp_resp = expected_resps.pop_front();
          if (m_axis_tuser !== exp_resp.status) begin
            $error("status: expected %0d, got %0d", exp_resp.status, m_axis_tuser);
            n_errors++;
          end
          if (m_axis_tdata !== exp_resp.mac) begin
            $error("mac_out: expected %h, got %h", exp_resp.mac, m_axis_tdata);
            n_errors++;
          end
        end
      end
      // watchdog: only counts while there is still work outstanding
      if (moved || (pending_reqs.size() == 0 && !s_axis_tvalid && expected_resps.size() == 0))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offers queued items at the falling edge, with random gaps.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    cache_req_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (in_taken || !s_axis_tvalid) begin
      if (in_taken && idling_allowed() && $urandom_range(0, 5) == 0)
        src_gap = $urandom_range(1, 14);
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.mac, req.ip};
        s_axis_tuser  <= req.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stall bursts, plus one long hold-off so the engine and
  // the output register both fill and the input side backs up.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!held_off && n_results >= 400) begin
        held_off  = 1'b1;
        sink_hold = HoldCycles;
      end else if (sink_hold == 0 && idling_allowed() && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(1, 14);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    logic [IpW-1:0] ip;
    int             pick;
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    shadow_used   = 0;
    n_errors      = 0;
    n_results     = 0;
    stall_cycles  = 0;
    src_gap       = 0;
    sink_hold     = 0;
    held_off      = 1'b0;

    // Directed: empty table, field extremes, duplicate address, table full.
    queue_item(OP_LOOKUP, 32'h0000_0000, '0);
    queue_item(OP_LOOKUP, 32'hFFFF_FFFF, '1);              // mac ignored on lookup
    queue_item(OP_INSERT, 32'h0000_0000, '0);
    queue_item(OP_INSERT, 32'hFFFF_FFFF, '1);
    queue_item(OP_LOOKUP, 32'h0000_0000, '1);              // hit with an all-zero MAC
    queue_item(OP_LOOKUP, 32'hFFFF_FFFF, '0);
    queue_item(OP_INSERT, 32'h0A00_0001, 48'h0200_0000_0001);
    queue_item(OP_INSERT, 32'h0A00_0001, 48'h0200_0000_0002); // duplicate takes a new row
    queue_item(OP_LOOKUP, 32'h0A00_0001, '0);              // lowest row's MAC expected
    queue_item(OP_LOOKUP, 32'h0A00_0002, '0);              // miss on a partial table
    for (int i = 4; i < Entries; i++)
      queue_item(OP_INSERT, $urandom, rand_mac());
    queue_item(OP_INSERT, $urandom, rand_mac());           // full, nothing stored
    queue_item(OP_LOOKUP, known_ips[Entries-1], rand_mac()); // hit on the last row
    queue_item(OP_LOOKUP, 32'h5A5A_A5A5, rand_mac());      // full-length miss

    // Random: mostly lookups of stored addresses, near misses and inserts.
    for (int n = 0; n < RandItems; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        queue_item(OP_INSERT, $urandom, rand_mac());
      end else if (pick < 70) begin
        queue_item(OP_LOOKUP, known_ips[$urandom_range(0, Entries-1)], rand_mac());
      end else if (pick < 85) begin
        ip = known_ips[$urandom_range(0, Entries-1)];
        ip[$urandom_range(0, IpW-1)] ^= 1'b1;             // one bit off a stored address
        queue_item(OP_LOOKUP, ip, rand_mac());
      end else begin
        queue_item(OP_LOOKUP, $urandom, rand_mac());
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (n_errors == 0 && expected_resps.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
